// ===== src/sorted_list_insert_remove_assert.svh =====
// assertion macros for the sorted list block
// used by the top level only, expects clk and rst_n in scope
`ifndef SORTED_LIST_INSERT_REMOVE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication
`define SLRI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// next-cycle implication
`define SLRI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list sequencing check failed");

`endif

// ===== src/slri_pkg.sv =====
// shared types and constants for the sorted list insert/remove block
// no dependencies
package slri_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int CNT_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic report;
    } slri_cmd_t;

endpackage

// ===== src/slri_datapath.sv =====
// sorted cell chain, fill counter and result register
// depends on slri_pkg
module slri_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  slri_pkg::slri_cmd_t              cmd,
    input  logic                             in_op,
    input  logic signed [slri_pkg::VAL_W-1:0] in_value,
    output slri_pkg::status_t                res_status,
    output logic [slri_pkg::CNT_W-1:0]       res_count,
    output logic signed [slri_pkg::VAL_W-1:0] res_smallest,
    output logic signed [slri_pkg::VAL_W-1:0] res_largest
);
    import slri_pkg::*;

    logic                     op_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic signed [VAL_W-1:0]  ent_reg  [CAPACITY];
    logic signed [VAL_W-1:0]  ent_next [CAPACITY];
    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;
    logic [FILL_W-1:0]        last_fill;
    status_t                  stat_reg;
    status_t                  stat_next;
    logic [CAPACITY-1:0]      valid;
    logic [CAPACITY-1:0]      gt;
    logic [CAPACITY-1:0]      ge;
    logic [CAPACITY-1:0]      eq;
    logic                     full;
    logic                     found;
    logic                     any_gt;
    status_t                  out_stat_reg;
    logic [CNT_W-1:0]         out_cnt_reg;
    logic signed [VAL_W-1:0]  out_min_reg;
    logic signed [VAL_W-1:0]  out_max_reg;

    // per-cell compares against the item value
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid[i] = FILL_W'(i) < fill_reg;
            gt[i]    = valid[i] && (ent_reg[i] >  val_reg);
            ge[i]    = valid[i] && (ent_reg[i] >= val_reg);
            eq[i]    = valid[i] && (ent_reg[i] == val_reg);
        end
    end

    assign full   = (fill_reg == FILL_W'(CAPACITY));
    assign found  = |eq;
    assign any_gt = |gt;

    // cell updates: insert shifts the larger tail up, remove pulls the tail down
    always_comb
    begin
        fill_next = fill_reg;
        stat_next = STAT_DONE;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        unique case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    fill_next = fill_reg + FILL_W'(1);
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                        begin
                            ent_next[i] = ent_reg[(i > 0) ? i - 1 : 0];
                        end
                        else if (gt[i] || (FILL_W'(i) == fill_reg && !any_gt))
                        begin
                            ent_next[i] = val_reg;
                        end
                    end
                end
            end
            OP_REMOVE:
            begin
                if (!found)
                begin
                    stat_next = STAT_NOT_FOUND;
                end
                else
                begin
                    fill_next = fill_reg - FILL_W'(1);
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (ge[i])
                        begin
                            ent_next[i] = ent_reg[i + 1];
                        end
                    end
                end
            end
            default:
            begin
                stat_next = STAT_DONE;
            end
        endcase
    end

    assign last_fill = fill_reg - FILL_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            val_reg <= in_value;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                ent_reg[i] <= ent_next[i];
            end
            stat_reg <= stat_next;
        end
        if (cmd.report)
        begin
            out_stat_reg <= stat_reg;
            out_cnt_reg  <= CNT_W'(fill_reg);
            out_min_reg  <= (fill_reg == '0) ? '0 : ent_reg[0];
            out_max_reg  <= (fill_reg == '0) ? '0 : ent_reg[last_fill[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.exec)
        begin
            fill_reg <= fill_next;
        end
    end

    assign res_status   = out_stat_reg;
    assign res_count    = out_cnt_reg;
    assign res_smallest = out_min_reg;
    assign res_largest  = out_max_reg;

endmodule

// ===== src/slri_controller.sv =====
// sequencing state machine and stream handshakes
// depends on slri_pkg
module slri_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output slri_pkg::slri_cmd_t cmd
);
    import slri_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    // input side only waits for the sequencer, a pending result is held at report
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    cmd.report     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== src/sorted_list_insert_remove.sv =====
// Sorted list of up to 16 signed 32-bit values kept in ascending order in a
// chain of compare cells. Each input word (tuser: 0 insert, 1 remove) goes
// through capture, one cell-chain update, and loading of the result
// register; the three-state sequencer takes no new word until it has loaded
// the result of the last one. The result register holds one word while the
// next input is accepted and processed; if that word is still unread when the
// next result is due, the sequencer waits in its report step until it leaves.
// Result: status, count, smallest and largest (0 when the list is empty).
// No clearing pass is needed after reset.
// depends on slri_pkg, slri_controller, slri_datapath and the assertion header
`include "sorted_list_insert_remove_assert.svh"

module sorted_list_insert_remove
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // status[1:0], count[6:2], smallest[38:7],
                                   // largest[70:39], zero[71]
);
    import slri_pkg::*;

    slri_cmd_t               cmd;
    status_t                 res_status;
    logic [CNT_W-1:0]        res_count;
    logic signed [VAL_W-1:0] res_smallest;
    logic signed [VAL_W-1:0] res_largest;

    slri_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    slri_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_op        (s_tuser),
        .in_value     (s_tdata),
        .res_status   (res_status),
        .res_count    (res_count),
        .res_smallest (res_smallest),
        .res_largest  (res_largest)
    );

    assign m_tdata = {1'b0, res_largest, res_smallest, res_count, res_status};

    // block is busy right after taking a word
    `SLRI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // a dropped insert means the list is at capacity
    `SLRI_ASSERT_SAME(a_full_count, m_tvalid && (res_status == STAT_FULL),
        res_count == CNT_W'(CAPACITY))
    // ordering of the cell chain shows in the summary
    `SLRI_ASSERT_SAME(a_min_le_max, m_tvalid, res_smallest <= res_largest)
    // empty list reports zeros
    `SLRI_ASSERT_SAME(a_empty_zero, m_tvalid && (res_count == '0),
        (res_smallest == '0) && (res_largest == '0))

endmodule

// ===== test/tb_sorted_list_insert_remove.sv =====
// self-checking testbench for sorted_list_insert_remove: inserts and removes signed words
// and checks status, count, smallest and largest against a queue-based sorted store
// depends on slri_pkg and the sorted_list_insert_remove rtl
module tb_sorted_list_insert_remove;

    import slri_pkg::*;

    typedef struct {
        status_t            status;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value[31:0]
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // status[1:0], count[6:2], smallest[38:7], largest[70:39], zero[71]

    logic signed [31:0] sorted_store[$];
    report_t            pending_reports[$];
    int                 mismatches;
    int                 words_sent;
    int                 inserts_seen;
    int                 removes_seen;
    int                 full_drops;
    int                 misses;
    bit                 steady_source;
    bit                 steady_sink;

    sorted_list_insert_remove u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // mostly short idles, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // applies one word to the sorted store and returns what the block should report
    function automatic report_t store_apply(logic op, logic signed [31:0] v);
        report_t rep;
        int      slot;
        rep.status = STAT_DONE;
        if (op == OP_INSERT)
        begin
            inserts_seen++;
            if (sorted_store.size() >= CAPACITY)
            begin
                rep.status = STAT_FULL;
                full_drops++;
            end
            else
            begin
                // equal values stay in arrival order
                slot = sorted_store.size();
                for (int i = 0; i < sorted_store.size(); i++)
                begin
                    if (sorted_store[i] > v)
                    begin
                        slot = i;
                        break;
                    end
                end
                sorted_store.insert(slot, v);
            end
        end
        else
        begin
            removes_seen++;
            slot = -1;
            for (int i = 0; i < sorted_store.size(); i++)
            begin
                if (sorted_store[i] == v)
                begin
                    slot = i;
                    break;
                end
            end
            if (slot < 0)
            begin
                rep.status = STAT_NOT_FOUND;
                misses++;
            end
            else
                sorted_store.delete(slot);
        end
        rep.count = CNT_W'(sorted_store.size());
        if (sorted_store.size() == 0)
        begin
            rep.smallest = '0;
            rep.largest  = '0;
        end
        else
        begin
            rep.smallest = sorted_store[0];
            rep.largest  = sorted_store[sorted_store.size() - 1];
        end
        return rep;
    endfunction

    // biased so that removes usually hit and duplicates are common
    function automatic logic signed [31:0] pick_value(bit for_remove);
        int r;
        r = $urandom_range(0, 99);
        if (for_remove && sorted_store.size() > 0 && r < 60)
            return sorted_store[$urandom_range(0, sorted_store.size() - 1)];
        else if (r < 75)
            return $signed($urandom_range(0, 8)) - 4;
        else if (r < 83)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        else
            return $urandom;
    endfunction

    task automatic send_word(input logic op, input logic signed [31:0] v);
        int gap;
        gap = steady_source ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_reports.push_back(store_apply(op, v));
        words_sent++;
    endtask

    task automatic send_random(input int n);
        logic op;
        for (int k = 0; k < n; k++)
        begin
            op = $urandom_range(0, 1) ? OP_REMOVE : OP_INSERT;
            send_word(op, pick_value(op == OP_REMOVE));
        end
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_word(OP_REMOVE, 32'sd3);             // remove from empty list
        send_word(OP_INSERT, 32'sd7);
        send_word(OP_REMOVE, 32'sd7);             // last entry leaves, list empty again
        send_word(OP_INSERT, 32'sh8000_0000);
        send_word(OP_INSERT, 32'sh7fff_ffff);
        send_word(OP_INSERT, 32'sd0);
        send_word(OP_INSERT, -32'sd1);
        send_word(OP_INSERT, 32'sd5);
        send_word(OP_INSERT, 32'sd5);             // duplicate goes after the first
        send_word(OP_REMOVE, 32'sd5);
        send_word(OP_REMOVE, 32'sd42);            // absent value
        while (sorted_store.size() < CAPACITY)
            send_word(OP_INSERT, $urandom);
        send_word(OP_INSERT, 32'sd1);             // full, dropped
    endtask

    task automatic test_random_traffic();
        send_random(540);
    endtask

    // swings the list between full and empty so both edges get hit often
    task automatic test_fill_and_drain();
        for (int round = 0; round < 6; round++)
        begin
            while (sorted_store.size() < CAPACITY)
                send_word(OP_INSERT, pick_value(1'b0));
            send_word(OP_INSERT, pick_value(1'b0));
            while (sorted_store.size() > 0)
                send_word(OP_REMOVE, pick_value(1'b1));
            send_word(OP_REMOVE, pick_value(1'b0));
        end
    endtask

    task automatic test_back_to_back();
        steady_source = 1'b1;
        steady_sink   = 1'b1;
        send_random(150);
        steady_sink = 1'b0;
        send_random(150);
        steady_source = 1'b0;
    endtask

    // sender holds off until every report is back, then resumes
    task automatic test_pause_until_empty();
        send_random(20);
        s_tvalid <= 1'b0;
        wait_drained();
        @(posedge clk);
        send_random(20);
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin : sink_stalls
            int hold;
            @(posedge clk);
            if (steady_sink)
            begin
                m_tready <= 1'b1;
                hold = 0;
            end
            else if (hold > 0)
                hold--;
            else
            begin
                m_tready <= $urandom_range(0, 3) != 0;
                hold = pick_gap();
            end
        end
    end

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t unexpected result word: expected none, actual %0h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                compare_field("count", 32'(want.count), 32'(m_tdata[6:2]));
                compare_field("smallest", want.smallest, m_tdata[38:7]);
                compare_field("largest", want.largest, m_tdata[70:39]);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= OP_INSERT;
        mismatches    = 0;
        words_sent    = 0;
        inserts_seen  = 0;
        removes_seen  = 0;
        full_drops    = 0;
        misses        = 0;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic();
        test_pause_until_empty();
        test_fill_and_drain();
        test_back_to_back();

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d words: %0d inserts (%0d dropped while full), %0d removes (%0d misses)",
                 words_sent, inserts_seen, full_drops, removes_seen, misses);
        $display("mismatches found: %0d", mismatches + pending_reports.size());
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/slri_pkg.sv
src/slri_datapath.sv
src/slri_controller.sv
src/sorted_list_insert_remove.sv
test/tb_sorted_list_insert_remove.sv
